// ----- design/epsm_pkg.sv -----
// Shared constants and types for the encoder period speed meter.
`default_nettype none
package epsm_pkg;
	localparam int CAP_W            = 16;
	localparam int CP_W             = 17;
	localparam int GR_W             = 16;
	localparam int DIR_W            = 2;
	localparam int PER_W            = 19;
	localparam int PMAG_W           = 18;
	localparam int DEN_W            = PMAG_W + GR_W;
	localparam int QUOT_W           = 31;
	localparam int SPEED_W          = 32;
	localparam int COUNT_W          = 32;
	localparam int TOTAL_W          = 33;
	localparam int CFG_IDX_W        = 1;
	localparam int CAPTURE_BITS_DEF = 16;

	localparam logic [QUOT_W-1:0]  SPEED_NUM = 31'd1536000000;
	localparam logic [SPEED_W-1:0] SPEED_SAT = 32'd1536000000;
	localparam logic [CP_W-1:0]    CP_RESET  = 17'd50000;
	localparam logic [GR_W-1:0]    GR_RESET  = 16'd738;

	localparam logic [CFG_IDX_W-1:0] REG_COUNTER_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GEAR_RATIO     = 1'b1;

	localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_res_t;
endpackage
`default_nettype wire

// ----- design/epsm_div.sv -----
// Restoring divider: constant speed numerator over the period-ratio product, one bit per cycle.
`default_nettype none
module epsm_div import epsm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DEN_W-1:0] denom,
	output div_res_t              res
);
	localparam int STEP_W = $clog2(QUOT_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [QUOT_W-1:0] num_q;
	logic [QUOT_W-1:0] quot_q;
	logic [DEN_W:0]    rem_sh;
	logic [DEN_W+1:0]  diff;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, num_q[QUOT_W-1]};
		diff   = {1'b0, rem_sh} - {2'b00, den_q};
		ge     = ~diff[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= denom;
			rem_q  <= '0;
			num_q  <= SPEED_NUM;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			num_q  <= {num_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
endmodule
`default_nettype wire

// ----- design/encoder_period_speed_meter_core.sv -----
// Top level: two-channel encoder period speed meter with pulse counters.
// A speed that needs a division passes through multiply, load, 31 divider steps, done and
// the output register; a saturated speed or a stopped direction skips the load and divider.
// Input is taken only in the idle state, so a new item waits until the previous result is
// registered for output; a stalled result holds it back.
// Reset: asynchronous, clears captures, counts and the sequencer; registers reload defaults.
`default_nettype none
module encoder_period_speed_meter_core import epsm_pkg::*; #(
	parameter int CAPTURE_BITS = CAPTURE_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	input  wire logic [23:0]          s_tdata,  // capture_value[15:0], direction[17:16], zero
	input  wire logic                 s_tuser,  // channel
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	output      logic [103:0]         m_tdata,  // speed_q8[31:0], pulse_count[63:32], total_count[96:64], zero
	output      logic                 m_tuser,  // out_channel
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CP_W-1:0]      cfg_data
);
	localparam int KEEP_BITS = (CAPTURE_BITS < CAP_W) ? CAPTURE_BITS : CAP_W;
	localparam logic [CAP_W-1:0] CAP_MASK = {CAP_W{1'b1}} >> (CAP_W - KEEP_BITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]         state_q;
	logic [CP_W-1:0]    cp_q;
	logic [GR_W-1:0]    gr_q;
	logic [CAP_W-1:0]   last_cap_q [2];
	logic [COUNT_W-1:0] cnt_q [2];

	logic               ch_q;
	logic [DIR_W-1:0]   dir_q;
	logic               sat_q;
	logic [PMAG_W-1:0]  per_q;
	logic [DEN_W-1:0]   den_q;
	logic [QUOT_W-1:0]  mag_q;
	logic [COUNT_W-1:0] pulse_q;
	logic [TOTAL_W-1:0] total_q;

	logic               out_valid_q;
	logic               out_ch_q;
	logic [103:0]       out_data_q;

	logic               accept;
	logic               in_ch;
	logic [CAP_W-1:0]   in_cap;
	logic [DIR_W-1:0]   in_dir;
	logic [CAP_W-1:0]   last;
	logic [PER_W-1:0]   per;
	logic               in_sat;
	logic               active;
	logic               out_free;
	logic [SPEED_W-1:0] mag;
	logic [SPEED_W-1:0] speed;
	logic               div_start;
	div_res_t           div_res;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign in_ch    = s_tuser;
	assign in_cap   = s_tdata[15:0] & CAP_MASK;
	assign in_dir   = s_tdata[17:16];
	assign last     = last_cap_q[in_ch];
	assign active   = ((dir_q == DIR_FWD) || (dir_q == DIR_REV)) && !sat_q;
	assign out_free = !out_valid_q || m_tready;
	assign div_start = (state_q == ST_LOAD);

	always_comb begin
		if (in_cap < last)
			per = {3'b000, in_cap} + {2'b00, cp_q} - {3'b000, last};
		else
			per = {3'b000, in_cap} - {3'b000, last};
		in_sat = per[PER_W-1] || (per == '0) || (gr_q == '0);
	end

	always_comb begin
		mag = sat_q ? SPEED_SAT : {1'b0, mag_q};
		if (dir_q == DIR_FWD)
			speed = mag;
		else if (dir_q == DIR_REV)
			speed = -mag;
		else
			speed = '0;
	end

	epsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.denom  (den_q),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q <= CP_RESET;
			gr_q <= GR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNTER_PERIOD: cp_q <= cfg_data;
				REG_GEAR_RATIO:     gr_q <= cfg_data[GR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cap_q[0] <= '0;
			last_cap_q[1] <= '0;
			cnt_q[0]      <= '0;
			cnt_q[1]      <= '0;
		end else if (accept) begin
			last_cap_q[in_ch] <= in_cap;
			if (in_dir == DIR_FWD)
				cnt_q[in_ch] <= cnt_q[in_ch] - 1'b1;
			else if (in_dir == DIR_REV)
				cnt_q[in_ch] <= cnt_q[in_ch] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_MUL;
				ST_MUL:  state_q <= active ? ST_LOAD : ST_DONE;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV:  if (div_res.done) state_q <= ST_DONE;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q  <= in_ch;
			dir_q <= in_dir;
			sat_q <= in_sat;
			per_q <= per[PMAG_W-1:0];
		end
		if (state_q == ST_MUL) begin
			den_q   <= per_q * gr_q;
			pulse_q <= cnt_q[ch_q];
			total_q <= {cnt_q[0][COUNT_W-1], cnt_q[0]} + {cnt_q[1][COUNT_W-1], cnt_q[1]};
		end
		if ((state_q == ST_DIV) && div_res.done)
			mag_q <= div_res.quot;
		if ((state_q == ST_DONE) && out_free) begin
			out_ch_q   <= ch_q;
			out_data_q <= {7'b0, total_q, pulse_q, speed};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_ch_q;
endmodule
`default_nettype wire

// ----- design/epsm_checker.sv -----
// Port-level assertions for the speed meter core, bound to the top level.
`default_nettype none
module epsm_checker import epsm_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [103:0]         m_tdata,
	input wire logic                 m_tuser
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transaction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_speed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(SPEED_SAT))
			&& ($signed(m_tdata[31:0]) >= -$signed(SPEED_SAT)))
		else $error("speed beyond saturation");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without work in progress");
endmodule

bind encoder_period_speed_meter_core epsm_checker u_epsm_checker (.*);
`default_nettype wire
